// ===== rtl/core/rcam_pkg.sv =====
// package for the reference-counted identifier table
// shared types, field widths and code constants; no dependencies
`timescale 1ns / 1ps

package rcam_pkg;

   localparam int KEY_W       = 22;
   localparam int COUNT_W     = 16;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // request codes; the unused code behaves as a query
   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_READ,
      ST_UPDATE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic capture;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage

// ===== rtl/core/rcam_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module rcam_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rcam_ctrl.sv =====
// sequencer for the identifier table: accept, compare, read, update
// depends on rcam_pkg
`timescale 1ns / 1ps

module rcam_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  rcam_pkg::sts_type sts,
   output rcam_pkg::cmd_type cmd
);

   import rcam_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      cmd.load_req = 1'b0;
      cmd.capture  = 1'b0;
      cmd.commit   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cmd.capture = 1'b1;
            state_in    = ST_READ;
         end
         ST_READ: begin
            // count ram read in flight
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/rcam_dp.sv =====
// datapath: key cells with parallel compare, valid bits, count ram, result register
// depends on rcam_pkg and rcam_ram
`timescale 1ns / 1ps

module rcam_dp #(
   parameter int ENTRIES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rcam_pkg::cmd_type                  cmd,
   output rcam_pkg::sts_type                  sts,
   input  logic [rcam_pkg::OP_W-1:0]          req_tuser,
   input  logic [rcam_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rcam_pkg::STATUS_W-1:0]      rsp_tuser,
   output logic [rcam_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   import rcam_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [OP_W-1:0]     op_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [ENTRIES-1:0]  match_ff;
   logic [ENTRIES-1:0]  free_ff;
   logic [ENTRIES-1:0]  valid_ff;
   logic [KEY_W-1:0]    slot_key_ff [ENTRIES];

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_present_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic [ENTRIES-1:0]  match_in;
   logic [ENTRIES-1:0]  free_in;
   logic                hit;
   logic                has_free;
   logic [IDX_W-1:0]    hit_idx;
   logic [IDX_W-1:0]    free_idx;
   logic [COUNT_W-1:0]  count_rd;
   logic [COUNT_W-1:0]  count_dec;

   logic [STATUS_W-1:0] res_status;
   logic                res_present;
   logic [COUNT_W-1:0]  res_count;
   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   logic [COUNT_W-1:0]  ram_wdata;
   logic                set_valid;
   logic                clr_valid;

   // one comparator per slot
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (slot_key_ff[i] == key_ff);
         free_in[i]  = !valid_ff[i];
      end
   end

   // lowest set bit wins
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (free_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign hit      = |match_ff;
   assign has_free = |free_ff;

   rcam_ram #(
      .WIDTH  (COUNT_W),
      .DEPTH  (ENTRIES),
      .ADDR_W (IDX_W)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (hit_idx),
      .rd_data (count_rd)
   );

   assign count_dec = (count_rd == '0) ? '0 : count_rd - COUNT_W'(1);

   always_comb begin
      res_status  = STATUS_OK;
      res_present = 1'b0;
      res_count   = '0;
      ram_we      = 1'b0;
      ram_waddr   = hit_idx;
      ram_wdata   = '0;
      set_valid   = 1'b0;
      clr_valid   = 1'b0;
      unique case (op_ff)
         OP_ADD: begin
            if (hit) begin
               res_present = 1'b1;
               if (count_rd == COUNT_MAX) begin
                  res_status = STATUS_OVERFLOW;
                  res_count  = count_rd;
               end else begin
                  ram_we    = cmd.commit;
                  ram_wdata = count_rd + COUNT_W'(1);
                  res_count = count_rd + COUNT_W'(1);
               end
            end else if (has_free) begin
               // insert into the lowest free slot
               ram_we      = cmd.commit;
               ram_waddr   = free_idx;
               ram_wdata   = COUNT_W'(1);
               set_valid   = 1'b1;
               res_present = 1'b1;
               res_count   = COUNT_W'(1);
            end else begin
               res_status = STATUS_FULL;
            end
         end
         OP_REMOVE: begin
            if (!hit) begin
               res_status = STATUS_NOT_FOUND;
            end else begin
               ram_we    = cmd.commit;
               ram_wdata = count_dec;
               if (count_dec == '0) begin
                  clr_valid = 1'b1;
               end else begin
                  res_present = 1'b1;
                  res_count   = count_dec;
               end
            end
         end
         default: begin
            if (hit) begin
               res_present = 1'b1;
               res_count   = count_rd;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_tuser;
         key_ff <= req_tdata[KEY_W-1:0];
      end
      if (cmd.capture) begin
         match_ff <= match_in;
         free_ff  <= free_in;
      end
      if (cmd.commit && set_valid) begin
         slot_key_ff[free_idx] <= key_ff;
      end
      if (cmd.commit) begin
         rsp_status_ff  <= res_status;
         rsp_present_ff <= res_present;
         rsp_count_ff   <= res_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit && set_valid) begin
            valid_ff[free_idx] <= 1'b1;
         end
         if (cmd.commit && clr_valid) begin
            valid_ff[hit_idx] <= 1'b0;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - COUNT_W - 1){1'b0}}, rsp_count_ff, rsp_present_ff};

   // a key never sits in two valid slots
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $onehot0(match_ff))
      else $error("identifier matched in more than one slot");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_present_ff |-> rsp_count_ff == '0)
      else $error("absent identifier reported with nonzero count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_present_ff |->
         (rsp_status_ff == STATUS_OK || rsp_status_ff == STATUS_OVERFLOW) &&
         rsp_count_ff != '0)
      else $error("present identifier with bad status or zero count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_OVERFLOW |-> rsp_count_ff == COUNT_MAX)
      else $error("overflow status without saturated count");

   assert property (@(posedge clock) disable iff (reset)
      cmd.commit && set_valid |=> valid_ff[$past(free_idx)])
      else $error("inserted slot not marked valid");

endmodule

// ===== rtl/core/refcounted_id_membership_table_top.sv =====
// Reference-counted identifier table, top level.
//
// Requests arrive on the req_ stream: req_tuser is the operation (add, remove,
// query) and req_tdata carries the 22-bit process identifier. Each request
// gives exactly one word on the rsp_ stream: rsp_tuser is the status (ok, not
// found, table full, count overflow), rsp_tdata holds the present flag and the
// 16-bit open count after the operation.
//
// Each request passes through capture, parallel key compare over all ENTRIES
// slots, count ram read and update; a new request is accepted only once the
// previous one has left the update step. The result is valid in the cycle
// after the update. The next request is taken while a result still waits in
// the output register; if the receiver holds rsp_tready low, the block waits
// in the update step until the output register is free, then continues.
//
// Reset clears all slot valid bits and the output valid flag at once; no
// clearing pass is needed, and the block accepts a request right after reset.
// depends on rcam_pkg, rcam_ctrl, rcam_dp, rcam_ram
`timescale 1ns / 1ps

module refcounted_id_membership_table_top #(
   parameter int ENTRIES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [rcam_pkg::OP_W-1:0]          req_tuser,  // req_type
   input  logic [rcam_pkg::REQ_TDATA_W-1:0]   req_tdata,  // process_id
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rcam_pkg::STATUS_W-1:0]      rsp_tuser,  // status
   output logic [rcam_pkg::RSP_TDATA_W-1:0]   rsp_tdata   // present, open_count
);

   import rcam_pkg::*;

   cmd_type cmd;
   sts_type sts;

   rcam_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rcam_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
